>>> design/fqsf_pkg.sv
// Shared types and constants for the sign-filtering FIFO queue.
package fqsf_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int KIND_W   = 3;
	localparam int OPND_W   = 32;
	localparam int AMOUNT_W = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH   = 3'd0,
		K_POP    = 3'd1,
		K_OCC    = 3'd2,
		K_CLEAR  = 3'd3,
		K_COUNT  = 3'd4,
		K_DROP   = 3'd5,
		K_INSERT = 3'd6,
		K_NOP    = 3'd7
	} req_kind_t;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PUSH,
		S_POP,
		S_CNT_EV,
		S_CNT_RD,
		S_DROP_EV,
		S_DROP_RD,
		S_NEG_EV,
		S_NEG_RD,
		S_INS_PREP,
		S_INS_RD,
		S_INS_EV,
		S_INS_ONE,
		S_FINISH,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH,
		OP_POP,
		OP_CNT_STEP,
		OP_DROP_STEP,
		OP_NEG_STEP,
		OP_INS_PREP,
		OP_INS_STEP,
		OP_INS_ONE,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		req_kind_t kind;
		logic      occ_zero;
		logic      occ_over;
		logic      idx_last;
		logic      idx_zero;
		logic      neg;
		logic      ins_full;
	} dp_stat_t;

endpackage

>>> design/fqsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> design/fqsf_ctrl.sv
// Controller state machine sequencing each request over the datapath.
module fqsf_ctrl import fqsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.kind)
					K_PUSH:   state_nx = S_PUSH;
					K_POP:    state_nx = S_POP;
					K_COUNT:  state_nx = stat.occ_zero ? S_FINISH : S_CNT_EV;
					K_DROP:   state_nx = stat.occ_zero ? S_FINISH : S_DROP_EV;
					K_INSERT: state_nx = stat.occ_zero ? S_FINISH : S_NEG_EV;
					default:  state_nx = S_FINISH;
				endcase
			end
			S_PUSH:    state_nx = S_FINISH;
			S_POP:     state_nx = S_FINISH;
			S_CNT_EV:  state_nx = stat.idx_last ? S_FINISH : S_CNT_RD;
			S_CNT_RD:  state_nx = S_CNT_EV;
			S_DROP_EV: state_nx = stat.idx_last ? S_FINISH : S_DROP_RD;
			S_DROP_RD: state_nx = S_DROP_EV;
			S_NEG_EV:  state_nx = stat.idx_last ? S_INS_PREP : S_NEG_RD;
			S_NEG_RD:  state_nx = S_NEG_EV;
			S_INS_PREP: state_nx = stat.ins_full ? S_FINISH : S_INS_RD;
			S_INS_RD:  state_nx = S_INS_EV;
			S_INS_EV: begin
				if (stat.neg) state_nx = S_INS_ONE;
				else state_nx = stat.idx_zero ? S_FINISH : S_INS_RD;
			end
			S_INS_ONE: state_nx = stat.idx_zero ? S_FINISH : S_INS_RD;
			S_FINISH:  state_nx = S_DONE;
			S_DONE: begin
				if (out_ready) state_nx = S_IDLE;
			end
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_PUSH:     cmd.op = OP_PUSH;
			S_POP:      cmd.op = OP_POP;
			S_CNT_EV:   cmd.op = OP_CNT_STEP;
			S_DROP_EV:  cmd.op = OP_DROP_STEP;
			S_NEG_EV:   cmd.op = OP_NEG_STEP;
			S_INS_PREP: cmd.op = OP_INS_PREP;
			S_INS_EV:   cmd.op = OP_INS_STEP;
			S_INS_ONE:  cmd.op = OP_INS_ONE;
			S_FINISH:   cmd.op = OP_FINISH;
			S_DONE:     out_valid = 1'b1;
			default:    cmd.op = OP_NONE;
		endcase
	end
endmodule

>>> design/fqsf_dp.sv
// Datapath: ring pointers, walk counters, slot RAM and result registers.
module fqsf_dp import fqsf_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [KIND_W-1:0]          req_type,
	input  logic signed [OPND_W-1:0]   operand,
	input  ctl_cmd_t                   cmd,
	output dp_stat_t                   stat,
	output logic signed [OPND_W-1:0]   data,
	output logic [AMOUNT_W-1:0]        amount,
	output logic [STATUS_W-1:0]        status
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	req_kind_t             kind_q;
	logic [DATA_WIDTH-1:0] opnd_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         occ_q, idx_q, cnt_q, tot_q, occ_new;
	logic signed [OPND_W-1:0] data_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic [CW-1:0]         woff;
	logic [CW:0]           rsum, wsum, ins_sum;
	logic signed [63:0]    opnd_ext, rd_ext;

	// Ring position: head plus an offset below twice the depth, folded once.
	assign rsum  = (CW+1)'(head_q) + (CW+1)'(idx_q);
	assign wsum  = (CW+1)'(head_q) + (CW+1)'(woff);
	assign raddr = (rsum >= (CW+1)'(DEPTH)) ? AW'(rsum - (CW+1)'(DEPTH)) : AW'(rsum);
	assign waddr = (wsum >= (CW+1)'(DEPTH)) ? AW'(wsum - (CW+1)'(DEPTH)) : AW'(wsum);

	assign opnd_ext = 64'(operand);
	assign rd_ext   = 64'($signed(rdata));
	assign ins_sum  = (CW+1)'(occ_q) + (CW+1)'(cnt_q);

	always_comb begin
		we    = 1'b0;
		woff  = cnt_q;
		wdata = rdata;
		case (cmd.op)
			OP_PUSH: begin
				woff  = occ_q;
				wdata = opnd_q;
				we    = (occ_q < CW'(DEPTH));
			end
			OP_DROP_STEP: we = ~rdata[DATA_WIDTH-1];
			OP_INS_STEP:  we = 1'b1;
			OP_INS_ONE: begin
				we    = 1'b1;
				wdata = DATA_WIDTH'(1);
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		case (kind_q)
			K_CLEAR:  occ_new = '0;
			K_DROP:   occ_new = cnt_q;
			K_INSERT: occ_new = (status_q == ST_OK) ? tot_q : occ_q;
			default:  occ_new = occ_q;
		endcase
	end

	fqsf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			kind_q <= K_NOP;
			idx_q  <= '0;
			cnt_q  <= '0;
			tot_q  <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					kind_q <= req_kind_t'(req_type);
					idx_q  <= '0;
					cnt_q  <= '0;
					tot_q  <= occ_q;
				end
				OP_PUSH: begin
					if (occ_q < CW'(DEPTH)) occ_q <= occ_q + 1'b1;
				end
				OP_POP: begin
					if (occ_q != '0) begin
						head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
						occ_q  <= occ_q - 1'b1;
					end
				end
				OP_CNT_STEP: begin
					if (rdata == opnd_q) cnt_q <= cnt_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				OP_DROP_STEP: begin
					if (!rdata[DATA_WIDTH-1]) cnt_q <= cnt_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				OP_NEG_STEP: begin
					if (rdata[DATA_WIDTH-1]) cnt_q <= cnt_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				OP_INS_PREP: begin
					tot_q <= CW'(ins_sum);
					cnt_q <= CW'(ins_sum - 1'b1);
					idx_q <= occ_q - 1'b1;
				end
				OP_INS_STEP: begin
					cnt_q <= cnt_q - 1'b1;
					if (!rdata[DATA_WIDTH-1]) idx_q <= idx_q - 1'b1;
				end
				OP_INS_ONE: begin
					cnt_q <= cnt_q - 1'b1;
					idx_q <= idx_q - 1'b1;
				end
				OP_FINISH: occ_q <= occ_new;
				default: ;
			endcase
		end
	end

	// Result registers hold their value while the receiver stalls.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				opnd_q   <= opnd_ext[DATA_WIDTH-1:0];
				data_q   <= '0;
				status_q <= ST_OK;
			end
			OP_PUSH: begin
				if (occ_q >= CW'(DEPTH)) status_q <= ST_FULL;
			end
			OP_POP: begin
				if (occ_q == '0) status_q <= ST_EMPTY;
				else data_q <= rd_ext[OPND_W-1:0];
			end
			OP_INS_PREP: begin
				if (ins_sum > (CW+1)'(DEPTH)) status_q <= ST_FULL;
			end
			OP_FINISH: amount_q <= (kind_q == K_COUNT) ? AMOUNT_W'(cnt_q) : AMOUNT_W'(occ_new);
			default: ;
		endcase
	end

	assign stat.kind     = kind_q;
	assign stat.occ_zero = (occ_q == '0);
	assign stat.occ_over = (occ_q > CW'(DEPTH));
	assign stat.idx_last = (idx_q == occ_q - 1'b1);
	assign stat.idx_zero = (idx_q == '0);
	assign stat.neg      = rdata[DATA_WIDTH-1];
	assign stat.ins_full = (ins_sum > (CW+1)'(DEPTH));

	assign data   = data_q;
	assign amount = amount_q;
	assign status = status_q;
endmodule

>>> design/fifo_queue_with_sign_filter.sv
// Top level of the bounded FIFO queue with match count and sign filters.
//
// Input channel (in_valid/in_ready) carries one request transaction:
// req_type selects push, pop, occupancy, clear, count matches, drop
// negatives or insert a one before each negative; operand is the value to
// push or to count. Output channel (out_valid/out_ready) returns exactly
// one result transaction per request: data (popped word, else 0), amount
// (match count, else occupancy after the request) and status (ok, pop on
// empty, rejected as full).
//
// Requests are served one at a time; in_ready is high only when idle.
// Push and pop each have their own datapath state; occupancy, clear,
// the unused kind and any walk over an empty queue go straight to the
// finish state. Count and drop make one pass over the stored entries;
// insert makes two (first pass counts negatives, second pass writes back
// from the tail) and stops after the first when rejected as full. The
// slot RAM's single read port with its registered read means entries are
// read and evaluated in separate states. The controller goes back to
// idle after the result is taken.
//
// Reset clears head, occupancy and the controller; slot contents are not
// cleared. While the receiver holds out_ready low the result stays
// registered and no new request is taken.
module fifo_queue_with_sign_filter import fqsf_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        req_type,
	input  logic signed [OPND_W-1:0] operand,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OPND_W-1:0] data,
	output logic [AMOUNT_W-1:0]      amount,
	output logic [STATUS_W-1:0]      status
);
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Controller: sequences each request; count, drop and insert walk the entries through read and evaluate steps.
	fqsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: ring buffer RAM, pointers and result registers.
	fqsf_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_type (req_type),
		.operand  (operand),
		.cmd      (cmd),
		.stat     (stat),
		.data     (data),
		.amount   (amount),
		.status   (status)
	);

	// Never take a request while a result is on offer.
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("request taken while result pending");

	// Occupancy never exceeds the depth.
	assert property (@(posedge clk) disable iff (!arst_n) !stat.occ_over)
		else $error("occupancy above depth");

	// An empty pop reports zero data and zero occupancy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (data == '0 && amount == '0))
		else $error("empty pop with non-zero result");

	// Status is one of the three defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("undefined status code");
endmodule
